>>> design/eprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eprt_pkg: shared types and constants of the echo pulse ranging timer
// Item opcodes, read status codes, register indexes, reset values and the
// request/status bundles between the control logic and the result store.
// ----------------------------------------------------------------------------
package eprt_pkg;

	// Entry and field widths
	localparam int DUR_W     = 32;
	localparam int ENTRY_W   = DUR_W + 1;
	localparam int MARK_BIT  = DUR_W;
	localparam int TRIG_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	// Register reset values and the duration count ceiling
	localparam logic [TRIG_W-1:0] TRIG_RESET    = 16'd20;
	localparam logic [DUR_W-1:0]  TIMEOUT_RESET = 32'd50000;
	localparam logic [DUR_W-1:0]  DUR_MAX       = '1;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_TRIG = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_NOREAD  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIG    = 1'b0,
		REG_TIMEOUT = 1'b1
	} cfg_idx_t;

	// Request from control to store, one beat at most per cycle
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [ENTRY_W-1:0] entry;
	} fifo_req_t;

	// Store status seen by control
	typedef struct packed {
		logic empty;
		logic full;
		logic empty_next;
	} fifo_stat_t;

endpackage

>>> design/eprt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eprt_store: result FIFO of the ranging timer
// One synchronous memory with a registered read port, plus read and write
// pointers. One slot stays free, so DEPTH slots hold DEPTH-1 entries.
// ----------------------------------------------------------------------------
module eprt_store #(
	parameter int DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  eprt_pkg::fifo_req_t           req,
	output eprt_pkg::fifo_stat_t          stat,
	output logic [eprt_pkg::ENTRY_W-1:0]  rd_data
);
	import eprt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_d, wr_ptr_d;
	logic [PTR_W-1:0]   rd_nxt, wr_nxt;
	logic [ENTRY_W-1:0] rd_data_q;
	logic               do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Work out occupancy and the pointers after this beat
	always_comb begin
		wr_nxt          = ptr_inc(wr_ptr_q);
		rd_nxt          = ptr_inc(rd_ptr_q);
		stat.empty      = (rd_ptr_q == wr_ptr_q);
		stat.full       = (wr_nxt == rd_ptr_q);
		do_push         = req.push && !stat.full;
		do_pop          = req.pop && !stat.empty;
		wr_ptr_d        = do_push ? wr_nxt : wr_ptr_q;
		rd_ptr_d        = do_pop ? rd_nxt : rd_ptr_q;
		stat.empty_next = (rd_ptr_d == wr_ptr_d);
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
		end
	end

	// Write on push, read the head on pop; read data holds otherwise
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= req.entry;
		end
		if (req.pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	assign rd_data = rd_data_q;

`ifndef SYNTH
	// A dropped push leaves the write pointer where it was
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		req.push && stat.full |=> $stable(wr_ptr_q))
		else $error("push into a full store moved the write pointer");

	// Control never pushes and pops in the same beat
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.push && req.pop))
		else $error("push and pop in the same cycle");
`endif

endmodule

>>> design/echo_pulse_ranging_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_ranging_timer: ultrasonic echo ranging timer
// Tick, trigger and read items drive the trigger pulse, the echo duration
// count, the timeout, and a FIFO of results kept in one memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, opcode, echo_level): one item per beat.
//    Tick items sample echo_level, trigger items start a pulse, read items
//    pop one result from the FIFO.
//  - Output channel (out_valid/out_ready): exactly one result beat per item,
//    in order: trigger pin level, read status, duration and data_available.
//  - Config port (cfg_wen/cfg_index/cfg_wdata): single-cycle register writes,
//    taken only while no item is in flight; the user must keep to this, the block does not enforce it.
//  - Throughput: one item per cycle unless the output stalls; control state
//    updates in the accept cycle, and the FIFO memory read port is used once
//    per read item that pops an entry.
//  - Result path: the memory read and the middle stage load at the accept
//    edge, then the output register loads from them when it may advance.
//  - Reset clears all control state and pointers and loads the register
//    defaults; the FIFO memory itself is not cleared.
//  - A stalled receiver holds the output register; at most one more item is
//    taken into the middle stage, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module echo_pulse_ranging_timer #(
	parameter int FIFO_DEPTH = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic                            echo_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            trig_level,
	output logic [1:0]                      read_status,
	output logic [eprt_pkg::DUR_W-1:0]      read_value,
	output logic                            data_available,
	input  logic                            cfg_wen,
	input  logic [eprt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [eprt_pkg::CFG_W-1:0]      cfg_wdata
);
	import eprt_pkg::*;

	// Configuration registers
	logic [TRIG_W-1:0] trig_cfg_q;
	logic [DUR_W-1:0]  timeout_cfg_q;

	// Control state
	logic              prev_q, started_q, armed_q;
	logic [DUR_W-1:0]  ecount_q, tcount_q;
	logic [TRIG_W-1:0] pcount_q;
	logic              prev_d, started_d, armed_d;
	logic [DUR_W-1:0]  ecount_d, tcount_d;
	logic [TRIG_W-1:0] pcount_d;

	// Store interface
	fifo_req_t          req;
	fifo_stat_t         stat;
	logic [ENTRY_W-1:0] rd_data;

	// Middle stage
	logic valid_s1, trig_s1, rd_s1, empty_s1, avail_s1;

	// Output register
	logic              out_valid_q, trig_q, avail_q;
	status_t           status_q;
	logic [DUR_W-1:0]  value_q;

	logic    accept, s1_adv;
	op_t     op;
	status_t status_s1;

	assign op       = op_t'(opcode);
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	// Load configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_cfg_q    <= TRIG_RESET;
			timeout_cfg_q <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TRIG:    trig_cfg_q    <= cfg_wdata[TRIG_W-1:0];
				REG_TIMEOUT: timeout_cfg_q <= cfg_wdata[DUR_W-1:0];
				default:     ;
			endcase
		end
	end

	// Next control state and store request for the accepted item
	always_comb begin
		logic rise, fall, high;
		prev_d    = prev_q;
		started_d = started_q;
		armed_d   = armed_q;
		ecount_d  = ecount_q;
		tcount_d  = tcount_q;
		pcount_d  = pcount_q;
		req       = '0;
		rise      = echo_level && !prev_q;
		fall      = !echo_level && prev_q;
		high      = echo_level && prev_q;
		if (accept) begin
			unique case (op)
				OP_TICK: begin
					// Edges first
					if (rise) begin
						started_d = 1'b1;
						ecount_d  = DUR_W'(1);
					end else if (high) begin
						if (started_q && ecount_q != DUR_MAX) begin
							ecount_d = ecount_q + 1'b1;
						end
					end else if (fall && started_q) begin
						armed_d   = 1'b0;
						req.push  = 1'b1;
						req.entry = {1'b0, ecount_q};
						started_d = 1'b0;
						ecount_d  = '0;
					end
					prev_d = echo_level;
					// Then the timeout countdown
					if (armed_d) begin
						if (tcount_q != '0) begin
							tcount_d = tcount_q - 1'b1;
						end
						if (tcount_d == '0) begin
							armed_d   = 1'b0;
							req.push  = 1'b1;
							req.entry = {1'b1, {DUR_W{1'b0}}};
						end
					end
					// Then the trigger pulse
					if (pcount_q != '0) begin
						pcount_d = pcount_q - 1'b1;
						if (pcount_d == '0) begin
							armed_d  = 1'b1;
							tcount_d = (timeout_cfg_q != '0) ? timeout_cfg_q : DUR_W'(1);
						end
					end
				end
				OP_TRIG: begin
					pcount_d = (trig_cfg_q != '0) ? trig_cfg_q : TRIG_W'(1);
				end
				OP_READ: begin
					req.pop = !stat.empty;
				end
				OP_NONE: ;
				default: ;
			endcase
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			started_q <= 1'b0;
			armed_q   <= 1'b0;
			ecount_q  <= '0;
			tcount_q  <= '0;
			pcount_q  <= '0;
		end else begin
			prev_q    <= prev_d;
			started_q <= started_d;
			armed_q   <= armed_d;
			ecount_q  <= ecount_d;
			tcount_q  <= tcount_d;
			pcount_q  <= pcount_d;
		end
	end

	eprt_store #(
		.DEPTH(FIFO_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.stat    (stat),
		.rd_data (rd_data)
	);

	// Middle stage: wait for the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trig_s1  <= (pcount_d != '0);
			rd_s1    <= (op == OP_READ);
			empty_s1 <= stat.empty;
			avail_s1 <= !stat.empty_next;
		end
	end

	// Decode read status from the popped entry
	always_comb begin
		if (!rd_s1) begin
			status_s1 = ST_NOREAD;
		end else if (empty_s1) begin
			status_s1 = ST_EMPTY;
		end else if (rd_data[MARK_BIT]) begin
			status_s1 = ST_TIMEOUT;
		end else begin
			status_s1 = ST_OK;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			trig_q   <= trig_s1;
			avail_q  <= avail_s1;
			status_q <= status_s1;
			value_q  <= (status_s1 == ST_OK) ? rd_data[DUR_W-1:0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign trig_level     = trig_q;
	assign read_status    = status_q;
	assign read_value     = value_q;
	assign data_available = avail_q;

`ifndef SYNTH
	// An armed timeout always has ticks left
	a_armed_count: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> tcount_q != '0)
		else $error("timeout armed with zero count");

	// No echo in progress means a cleared duration count
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> ecount_q == '0)
		else $error("duration count set without a rising edge");

	// A stalled middle stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1)
		else $error("middle stage lost a beat under stall");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the echo pulse ranging timer
// Drives tick, trigger and read items with bursty input and a stalling
// receiver, predicts every result beat in a scoreboard and compares each
// field in order. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
	import eprt_pkg::*;

	localparam int FIFO_DEPTH  = 128;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int QUIET_LIMIT = 2000;

	// One expected result beat
	typedef struct {
		logic             trig;
		status_t          status;
		logic [DUR_W-1:0] value;
		logic             avail;
	} echo_beat_t;

	// Scoreboard: own model of the timer plus the queue of expected beats
	class ranging_scoreboard;
		bit [ENTRY_W-1:0] records [FIFO_DEPTH];
		bit [PTR_W-1:0]   rd_ptr;
		bit [PTR_W-1:0]   wr_ptr;
		bit               echo_prev;
		bit               echo_active;
		bit [DUR_W-1:0]   echo_len;
		bit [TRIG_W-1:0]  pulse_left;
		bit [DUR_W-1:0]   timeout_left;
		bit               timeout_on;
		bit [TRIG_W-1:0]  trig_len;
		bit [DUR_W-1:0]   timeout_len;
		echo_beat_t       beats_q[$];
		int               errors;

		function new();
			trig_len    = TRIG_RESET;
			timeout_len = TIMEOUT_RESET;
		endfunction

		task report(string msg);
			errors++;
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		endtask

		function void set_reg(cfg_idx_t idx, bit [CFG_W-1:0] val);
			case (idx)
				REG_TRIG:    trig_len = val[TRIG_W-1:0];
				REG_TIMEOUT: timeout_len = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return beats_q.size();
		endfunction

		// Drop the record when the store is full
		function void push_record(bit [ENTRY_W-1:0] rec);
			bit [PTR_W-1:0] nxt;
			nxt = wr_ptr + 1'b1;
			if (nxt != rd_ptr) begin
				records[wr_ptr] = rec;
				wr_ptr = nxt;
			end
		endfunction

		// Edges first, then timeout countdown, then pulse countdown
		function void sample_echo(bit lvl);
			if (lvl && !echo_prev) begin
				echo_active = 1'b1;
				echo_len = DUR_W'(1);
			end else if (lvl && echo_prev) begin
				if (echo_active && echo_len != DUR_MAX)
					echo_len++;
			end else if (!lvl && echo_prev && echo_active) begin
				timeout_on = 1'b0;
				push_record({1'b0, echo_len});
				echo_active = 1'b0;
				echo_len = '0;
			end
			echo_prev = lvl;

			if (timeout_on) begin
				if (timeout_left != 0)
					timeout_left--;
				if (timeout_left == 0) begin
					timeout_on = 1'b0;
					push_record({1'b1, {DUR_W{1'b0}}});
				end
			end

			if (pulse_left != 0) begin
				pulse_left--;
				if (pulse_left == 0) begin
					timeout_on = 1'b1;
					timeout_left = (timeout_len != 0) ? timeout_len : DUR_W'(1);
				end
			end
		endfunction

		// Accepted input beat: advance the model and queue its result
		function void take_item(op_t op, bit lvl);
			echo_beat_t       b;
			bit [ENTRY_W-1:0] rec;
			b.status = ST_NOREAD;
			b.value  = '0;
			case (op)
				OP_TICK: sample_echo(lvl);
				OP_TRIG: pulse_left = (trig_len != 0) ? trig_len : TRIG_W'(1);
				OP_READ: begin
					if (rd_ptr == wr_ptr) begin
						b.status = ST_EMPTY;
					end else begin
						rec = records[rd_ptr];
						rd_ptr++;
						if (rec[MARK_BIT]) begin
							b.status = ST_TIMEOUT;
						end else begin
							b.status = ST_OK;
							b.value  = rec[DUR_W-1:0];
						end
					end
				end
				default: ;
			endcase
			b.trig  = (pulse_left != 0);
			b.avail = (rd_ptr != wr_ptr);
			beats_q.push_back(b);
		endfunction

		// Accepted output beat: compare with the oldest expectation
		task match_result(logic trig, logic [1:0] st, logic [DUR_W-1:0] val, logic avail);
			echo_beat_t b;
			if (beats_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				b = beats_q.pop_front();
				if (trig !== b.trig)
					report($sformatf("trig_level %b, want %b", trig, b.trig));
				if (st !== b.status)
					report($sformatf("read_status %0d, want %0d", st, b.status));
				if (val !== b.value)
					report($sformatf("read_value %0d, want %0d", val, b.value));
				if (avail !== b.avail)
					report($sformatf("data_available %b, want %b", avail, b.avail));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           opcode = OP_TICK;
	logic                 echo_level = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b1;
	logic                 trig_level;
	logic [1:0]           read_status;
	logic [DUR_W-1:0]     read_value;
	logic                 data_available;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TRIG;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	ranging_scoreboard sb;
	int                stall_mode = 0;
	bit   [15:0]       ready_pat = 16'hFFFF;
	bit   [3:0]        pat_pos = '0;
	bit                gaps_on = 1'b0;
	int                burst_left = 0;
	int                items_sent = 0;
	int                quiet_cycles = 0;

	echo_pulse_ranging_timer #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trig_level(trig_level),
		.read_status(read_status),
		.read_value(read_value),
		.data_available(data_available),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Note input beats, then check output beats
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.take_item(op_t'(opcode), echo_level);
		if (arst_n && out_valid && out_ready)
			sb.match_result(trig_level, read_status, read_value, data_available);
	end

	// Receiver stalls
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 99) >= 30);
			2: out_ready <= ready_pat[pat_pos];
			default: out_ready <= ($urandom_range(0, 99) >= 80);
		endcase
		pat_pos <= pat_pos + 1'b1;
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Hold one beat until accepted; called and returns at a falling edge
	task automatic send_item(op_t op, bit lvl);
		in_valid   <= 1'b1;
		opcode     <= op;
		echo_level <= lvl;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// With gaps on, send in bursts with random gaps between them
	task automatic send(op_t op, bit lvl);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0)
			burst_left--;
		send_item(op, lvl);
		if (op != OP_NONE)
			items_sent++;
	endtask

	// Drop valid and wait until every expected beat has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// Trigger, up to eight ticks, then an echo or silence, then reads; or a broken sequence
	task automatic measure();
		if ($urandom_range(0, 6) == 0) begin
			// Broken sequence: random items of any opcode, triggers included
			repeat ($urandom_range(1, 8))
				send(op_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)));
		end else begin
			send(OP_TRIG, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0) begin
				send(OP_TICK, 1'b0);
				send(OP_TRIG, 1'($urandom_range(0, 1)));
			end
			repeat ($urandom_range(0, 8))
				send(OP_TICK, ($urandom_range(0, 9) == 0));
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 12)) send(OP_TICK, 1'b1);
				send(OP_TICK, 1'b0);
			end else begin
				repeat ($urandom_range(1, 60)) send(OP_TICK, 1'b0);
			end
		end
		repeat ($urandom_range(0, 2)) send(OP_READ, 1'($urandom_range(0, 1)));
	endtask

	task automatic run_phase(bit [TRIG_W-1:0] trig, bit [CFG_W-1:0] tmo, int n_items,
			int stall, bit gaps);
		int goal;
		wait_idle();
		write_reg(REG_TRIG, {16'($urandom()), trig});
		write_reg(REG_TIMEOUT, tmo);
		stall_mode = stall;
		ready_pat  = 16'($urandom()) | 16'h0001;
		gaps_on    = gaps;
		goal       = items_sent + n_items;
		while (items_sent < goal) measure();
	endtask

	initial begin
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero trigger length acts as one, short timeout
		write_reg(REG_TRIG, 32'hA5A5_0000);
		write_reg(REG_TIMEOUT, 32'd3);
		send(OP_READ, 1'b1);          // empty store
		send(OP_NONE, 1'b1);          // ignored opcode
		send(OP_TICK, 1'b0);          // low echo, no edge
		send(OP_TRIG, 1'b1);          // echo on a non-tick item is ignored
		send(OP_TICK, 1'b0);          // pulse ends, timeout armed
		send(OP_TICK, 1'b1);          // rising edge
		send(OP_TICK, 1'b1);
		send(OP_TICK, 1'b0);          // falling edge pushes duration 2
		send(OP_READ, 1'b0);
		send(OP_TRIG, 1'b0);
		send(OP_TRIG, 1'b0);          // retrigger during pulse
		repeat (4) send(OP_TICK, 1'b0);  // timeout expires
		send(OP_READ, 1'b0);          // timeout entry
		send(OP_READ, 1'b0);
		send(OP_TICK, 1'b1);          // echo with no trigger still measured
		send(OP_TICK, 1'b1);
		send(OP_TICK, 1'b0);
		send(OP_READ, 1'b1);
		send(OP_NONE, 1'b0);

		// Zero timeout acts as one; then overfill the store and drain it
		wait_idle();
		write_reg(REG_TRIG, 32'h0000_0003);
		write_reg(REG_TIMEOUT, 32'd0);
		stall_mode = 2;
		ready_pat  = 16'hB6DB;
		gaps_on    = 1'b1;
		send(OP_TRIG, 1'b0);
		repeat (4) send(OP_TICK, 1'b0);
		send(OP_READ, 1'b0);
		repeat (140) begin
			send(OP_TICK, 1'b1);
			send(OP_TICK, 1'b0);
		end
		repeat (130) send(OP_READ, 1'($urandom_range(0, 1)));

		// Random phases across register settings and idling patterns
		run_phase(16'd1, 32'd1, 150, 0, 1'b0);
		run_phase(16'd4, 32'd25, 150, 1, 1'b1);
		run_phase(16'hFFFF, 32'hFFFF_FFFF, 80, 3, 1'b1);
		run_phase(16'd2, 32'd12, 150, 2, 1'b0);
		run_phase(TRIG_RESET, TIMEOUT_RESET, 100, 1, 1'b1);
		run_phase(16'($urandom_range(1, 8)), 32'($urandom_range(5, 40)), 150, 2, 1'b1);
		run_phase(16'd3, 32'd8, 100, 0, 1'b0);

		wait_idle();
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
design/eprt_pkg.sv
design/eprt_store.sv
design/echo_pulse_ranging_timer.sv
test/tb.sv
